[hw/rtl/dq_pkg.sv]
package dq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int REQ_W = 3;
   localparam int ENTRY_COUNT_W = 5;
   localparam int STATUS_W = 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -DATA_W'(1);

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_QUERY      = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_PUSH_FULL = 2'd2
   } status_code_type;

   typedef struct packed {
      logic update;
      logic capture;
      logic respond;
   } cmd_type;

endpackage

[hw/rtl/dq_ctrl.sv]
module dq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output dq_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign cmd.update  = (state_ff == S_IDLE) && start;
   assign cmd.capture = (state_ff == S_READ);
   assign cmd.respond = (state_ff == S_RESP);

`ifndef SYNTH
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> cmd.capture && busy)
      else $error("accepted request did not move on to the read cycle");

   a_read_to_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.respond)
      else $error("read cycle was not followed by the response");

   a_resp_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("block stayed busy after its response");
`endif

endmodule

[hw/rtl/dq_datapath.sv]
module dq_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dq_pkg::cmd_type                         cmd,
   input  logic [dq_pkg::REQ_W-1:0]                req_type,
   input  logic signed [dq_pkg::DATA_W-1:0]        req_value,
   output logic                                    rsp_valid,
   output logic signed [dq_pkg::DATA_W-1:0]        rsp_front_value,
   output logic signed [dq_pkg::DATA_W-1:0]        rsp_back_value,
   output logic [dq_pkg::ENTRY_COUNT_W-1:0]        rsp_entry_count,
   output logic                                    rsp_is_empty,
   output logic [dq_pkg::STATUS_W-1:0]             rsp_status
);

   logic signed [dq_pkg::DATA_W-1:0] store_ff [dq_pkg::DEPTH];

   logic [dq_pkg::IDX_W-1:0] front_ff;
   logic [dq_pkg::IDX_W-1:0] front_in;
   logic [dq_pkg::IDX_W-1:0] back_ff;
   logic [dq_pkg::IDX_W-1:0] back_in;
   logic [dq_pkg::CNT_W-1:0] count_ff;
   logic [dq_pkg::CNT_W-1:0] count_in;
   dq_pkg::status_code_type  status_ff;
   dq_pkg::status_code_type  status_in;

   logic signed [dq_pkg::DATA_W-1:0] rd_front_ff;
   logic signed [dq_pkg::DATA_W-1:0] rd_back_ff;

   logic                     wr_en;
   logic [dq_pkg::IDX_W-1:0] wr_addr;
   logic                     full;
   logic                     empty;
   logic [dq_pkg::IDX_W-1:0] front_prev;
   logic [dq_pkg::IDX_W-1:0] front_next;
   logic [dq_pkg::IDX_W-1:0] back_prev;
   logic [dq_pkg::IDX_W-1:0] back_next;
   logic                     is_push;

   assign full  = (count_ff >= dq_pkg::FULL_COUNT);
   assign empty = (count_ff == '0);

   assign front_prev = (front_ff == '0) ? dq_pkg::LAST_IDX : front_ff - 1'b1;
   assign front_next = (front_ff == dq_pkg::LAST_IDX) ? '0 : front_ff + 1'b1;
   assign back_prev  = (back_ff == '0) ? dq_pkg::LAST_IDX : back_ff - 1'b1;
   assign back_next  = (back_ff == dq_pkg::LAST_IDX) ? '0 : back_ff + 1'b1;

   assign is_push = (req_type == dq_pkg::REQ_PUSH_FRONT) ||
                    (req_type == dq_pkg::REQ_PUSH_BACK);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = dq_pkg::ST_DONE;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      unique case (req_type) inside
         dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
            if (full) begin
               status_in = dq_pkg::ST_PUSH_FULL;
            end else if (empty) begin
               wr_en    = 1'b1;
               wr_addr  = front_ff;
               back_in  = front_ff;
               count_in = dq_pkg::CNT_W'(1);
            end else if (req_type == dq_pkg::REQ_PUSH_FRONT) begin
               wr_en    = 1'b1;
               wr_addr  = front_prev;
               front_in = front_prev;
               count_in = count_ff + 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = back_next;
               back_in  = back_next;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
            if (empty) begin
               status_in = dq_pkg::ST_POP_EMPTY;
            end else begin
               if (count_ff > dq_pkg::CNT_W'(1)) begin
                  if (req_type == dq_pkg::REQ_POP_FRONT) begin
                     front_in = front_next;
                  end else begin
                     back_in = back_prev;
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = dq_pkg::ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && wr_en) begin
         store_ff[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_front_ff <= store_ff[front_ff];
         rd_back_ff  <= store_ff[back_ff];
      end
   end

   assign rsp_valid       = cmd.respond;
   assign rsp_is_empty    = empty;
   assign rsp_entry_count = dq_pkg::ENTRY_COUNT_W'(count_ff);
   assign rsp_status      = status_ff;
   assign rsp_front_value = empty ? dq_pkg::EMPTY_VALUE : rd_front_ff;
   assign rsp_back_value  = empty ? dq_pkg::EMPTY_VALUE : rd_back_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::FULL_COUNT)
      else $error("entry count exceeds the store depth");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.update && is_push && full
      |=> status_ff == dq_pkg::ST_PUSH_FULL && $stable(count_ff) && $stable(front_ff)
          && $stable(back_ff))
      else $error("push on a full queue changed the state");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.update && empty &&
      (req_type == dq_pkg::REQ_POP_FRONT || req_type == dq_pkg::REQ_POP_BACK)
      |=> status_ff == dq_pkg::ST_POP_EMPTY && count_ff == '0)
      else $error("pop on an empty queue was not ignored");

   a_state_held: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(count_ff) && $stable(front_ff) && $stable(back_ff))
      else $error("queue state moved without a request");
`endif

endmodule

[hw/rtl/double_ended_queue_unit.sv]
// Channel   Handshake                 Payload
// request   start, busy               req_type, req_value
// response  rsp_valid (strobe)        rsp_front_value, rsp_back_value, rsp_entry_count,
//                                     rsp_is_empty, rsp_status
//
// A request beat is taken when start is high and busy is low.
// Each request is handled in order: the update on acceptance, a registered read of
// both ends of the ring store, then the one-cycle response strobe.
// A new request can be taken on the cycle after the strobe, not before.
// Synchronous active-high reset empties the queue; stored values are left as they are.
// The receiver cannot hold off a response beat.
module double_ended_queue_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [dq_pkg::REQ_W-1:0]                req_type,
   input  logic signed [dq_pkg::DATA_W-1:0]        req_value,
   output logic                                    rsp_valid,
   output logic signed [dq_pkg::DATA_W-1:0]        rsp_front_value,
   output logic signed [dq_pkg::DATA_W-1:0]        rsp_back_value,
   output logic [dq_pkg::ENTRY_COUNT_W-1:0]        rsp_entry_count,
   output logic                                    rsp_is_empty,
   output logic [dq_pkg::STATUS_W-1:0]             rsp_status
);

   dq_pkg::cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   dq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

endmodule

[tb/double_ended_queue_unit_checker.sv]
`timescale 1ns / 100ps

module double_ended_queue_unit_checker
   import dq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [REQ_W-1:0]            req_type,
   input  logic signed [DATA_W-1:0]    req_value,
   input  logic                        rsp_valid,
   input  logic signed [DATA_W-1:0]    rsp_front_value,
   input  logic signed [DATA_W-1:0]    rsp_back_value,
   input  logic [ENTRY_COUNT_W-1:0]    rsp_entry_count,
   input  logic                        rsp_is_empty,
   input  logic [STATUS_W-1:0]         rsp_status,
   output int                          failures,
   output int                          outstanding
);

   typedef struct {
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     is_empty;
      logic [STATUS_W-1:0]      status;
   } deque_snapshot_type;

   logic signed [DATA_W-1:0] model_ring [DEPTH];
   logic [IDX_W-1:0]         model_front;
   logic [IDX_W-1:0]         model_back;
   logic [CNT_W-1:0]         model_count;
   deque_snapshot_type       due_snapshots [$];

   initial begin
      failures = 0;
      outstanding = 0;
   end

   function automatic logic [IDX_W-1:0] ring_step_up(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_step_down(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   task automatic advance_deque(input logic [REQ_W-1:0] code,
                                input logic signed [DATA_W-1:0] val,
                                output deque_snapshot_type snap);
      status_code_type outcome;
      outcome = ST_DONE;
      if (code == REQ_PUSH_FRONT || code == REQ_PUSH_BACK) begin
         if (model_count >= FULL_COUNT) begin
            outcome = ST_PUSH_FULL;
         end else if (model_count == '0) begin
            model_ring[model_front] = val;
            model_back = model_front;
            model_count = CNT_W'(1);
         end else if (code == REQ_PUSH_FRONT) begin
            model_front = ring_step_down(model_front);
            model_ring[model_front] = val;
            model_count = model_count + 1'b1;
         end else begin
            model_back = ring_step_up(model_back);
            model_ring[model_back] = val;
            model_count = model_count + 1'b1;
         end
      end else if (code == REQ_POP_FRONT || code == REQ_POP_BACK) begin
         if (model_count == '0) begin
            outcome = ST_POP_EMPTY;
         end else begin
            if (model_count > CNT_W'(1)) begin
               if (code == REQ_POP_FRONT) begin
                  model_front = ring_step_up(model_front);
               end else begin
                  model_back = ring_step_down(model_back);
               end
            end
            model_count = model_count - 1'b1;
         end
      end

      if (model_count == '0) begin
         snap.front_value = EMPTY_VALUE;
         snap.back_value = EMPTY_VALUE;
         snap.is_empty = 1'b1;
      end else begin
         snap.front_value = model_ring[model_front];
         snap.back_value = model_ring[model_back];
         snap.is_empty = 1'b0;
      end
      snap.entry_count = ENTRY_COUNT_W'(model_count);
      snap.status = outcome;
   endtask

   task automatic compare_field(input string field,
                                input logic signed [DATA_W:0] expected,
                                input logic signed [DATA_W:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, actual %0d", field, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      deque_snapshot_type predicted;
      deque_snapshot_type due;
      if (reset) begin
         model_front = '0;
         model_back = '0;
         model_count = '0;
         due_snapshots.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (due_snapshots.size() == 0) begin
               $error("response beat with no request outstanding");
               failures++;
            end else begin
               due = due_snapshots[0];
               due_snapshots.delete(0);
               compare_field("front_value", (DATA_W+1)'(due.front_value),
                             (DATA_W+1)'(rsp_front_value));
               compare_field("back_value", (DATA_W+1)'(due.back_value),
                             (DATA_W+1)'(rsp_back_value));
               compare_field("entry_count", (DATA_W+1)'(due.entry_count),
                             (DATA_W+1)'(rsp_entry_count));
               compare_field("is_empty", (DATA_W+1)'(due.is_empty),
                             (DATA_W+1)'(rsp_is_empty));
               compare_field("status", (DATA_W+1)'(due.status),
                             (DATA_W+1)'(rsp_status));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            advance_deque(req_type, req_value, predicted);
            due_snapshots = {due_snapshots, predicted};
         end
      end
      outstanding = due_snapshots.size();
   end

endmodule

[tb/double_ended_queue_unit_tb.sv]
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;
   import dq_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 267;
   localparam int MODE_SPAN = 30;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_PCT [3] = '{17, 77, 0};
   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic [REQ_W-1:0]           req_type = '0;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic signed [DATA_W-1:0]   rsp_front_value;
   logic signed [DATA_W-1:0]   rsp_back_value;
   logic [ENTRY_COUNT_W-1:0]   rsp_entry_count;
   logic                       rsp_is_empty;
   logic [STATUS_W-1:0]        rsp_status;

   int failures;
   int outstanding;
   int sender_idle_pct = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   double_ended_queue_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   double_ended_queue_unit_checker CHECK (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   task automatic issue_request(input logic [REQ_W-1:0] code,
                                input logic signed [DATA_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_type <= code;
      req_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   function automatic logic signed [DATA_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 3) return MOST_NEGATIVE;
      if (pick < 6) return MOST_POSITIVE;
      if (pick < 8) return EMPTY_VALUE;
      if (pick < 10) return '0;
      return $urandom;
   endfunction

   function automatic logic [REQ_W-1:0] random_code(input int push_pct);
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return REQ_W'($urandom_range(2**REQ_W - 1, REQ_QUERY));
      if (pick < 8 + push_pct) return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
   endfunction

   initial begin : stimulus
      int push_pct;
      push_pct = 46;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      issue_request(REQ_QUERY, random_value());
      issue_request(REQ_POP_FRONT, random_value());
      issue_request(REQ_POP_BACK, random_value());
      issue_request(REQ_PUSH_FRONT, MOST_NEGATIVE);
      issue_request(REQ_PUSH_BACK, MOST_POSITIVE);
      for (int k = int'(REQ_QUERY) + 1; k < 2**REQ_W; k++) begin
         issue_request(REQ_W'(k), random_value());
      end
      issue_request(REQ_POP_FRONT, random_value());
      issue_request(REQ_POP_BACK, random_value());
      for (int k = 0; k < DEPTH; k++) begin
         issue_request(k[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                       (k == 0) ? MOST_POSITIVE : (k == DEPTH - 1) ? MOST_NEGATIVE : $urandom);
      end
      issue_request(REQ_PUSH_FRONT, random_value());
      issue_request(REQ_PUSH_BACK, random_value());

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = IDLE_PCT[phase];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % MODE_SPAN == 0) begin
               case ($urandom_range(2))
                  0: begin
                     push_pct = 62;
                  end
                  1: begin
                     push_pct = 25;
                  end
                  default: begin
                     push_pct = 46;
                  end
               endcase
            end
            issue_request(random_code(push_pct), random_value());
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[double_ended_queue_unit.f]
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue_unit.sv
tb/double_ended_queue_unit_checker.sv
tb/double_ended_queue_unit_tb.sv
